### rtl/core/osx_pkg.sv
// Package for the opaque span extractor.
// Holds the word types of both channels, the configuration type and codes,
// and the default sizing constants. No dependencies.
package osx_pkg;

  // Default sizing of the frame geometry.
  localparam int DEF_MAX_FRAME_WIDTH  = 1024;
  localparam int DEF_MAX_FRAME_PIXELS = 65536;

  // Fixed field widths.
  localparam int PIXEL_W      = 8;
  localparam int FW_W         = 11;
  localparam int SPAN_START_W = 16;
  localparam int SPAN_LEN_W   = 11;
  localparam int COUNT_W      = 16;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = FW_W;

  localparam logic [FW_W-1:0]    FRAME_WIDTH_RESET = FW_W'(32);
  localparam logic [PIXEL_W-1:0] BACKGROUND_RESET  = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH      = 1'b0,
    CFG_BACKGROUND_COLOR = 1'b1
  } osx_cfg_idx_t;

  typedef struct packed {
    logic [FW_W-1:0]    frame_width;
    logic [PIXEL_W-1:0] background_color;
  } osx_cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               last_in_frame;
  } osx_in_t;

  typedef struct packed {
    logic                    span_valid;
    logic [SPAN_START_W-1:0] span_start;
    logic [SPAN_LEN_W-1:0]   span_length;
    logic                    frame_done;
    logic [COUNT_W-1:0]      zone_count;
  } osx_out_t;

endpackage

### rtl/core/osx_cfg_regs.sv
// Configuration registers of the opaque span extractor.
// Decodes the plain write port into frame width and background color.
// Depends on osx_pkg.
module osx_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [osx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [osx_pkg::CFG_DATA_W-1:0] cfg_data,
  output osx_pkg::osx_cfg_t              cfg
);
  import osx_pkg::*;

  osx_cfg_idx_t idx;

  assign idx = osx_cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width      <= FRAME_WIDTH_RESET;
      cfg.background_color <= BACKGROUND_RESET;
    end else if (cfg_write) begin
      unique case (idx)
        CFG_FRAME_WIDTH:      cfg.frame_width      <= cfg_data[FW_W-1:0];
        CFG_BACKGROUND_COLOR: cfg.background_color <= cfg_data[PIXEL_W-1:0];
      endcase
    end
  end

endmodule

### rtl/core/osx_span_tracker.sv
// Run tracking for the opaque span extractor: column, pixel index, run
// length, run start and span count, plus the result word of each pixel.
// Depends on osx_pkg.
module osx_span_tracker #(
  parameter int MAX_FRAME_WIDTH  = osx_pkg::DEF_MAX_FRAME_WIDTH,
  parameter int MAX_FRAME_PIXELS = osx_pkg::DEF_MAX_FRAME_PIXELS
) (
  input  logic              clk,
  input  logic              rst,
  input  osx_pkg::osx_cfg_t cfg,
  input  logic              accept,
  input  osx_pkg::osx_in_t  in_word,
  output logic              has_result,
  output osx_pkg::osx_out_t result
);
  import osx_pkg::*;

  localparam int COL_W = $clog2(MAX_FRAME_WIDTH);
  localparam int IDX_W = $clog2(MAX_FRAME_PIXELS);
  localparam int WID_W = ($clog2(MAX_FRAME_WIDTH + 1) > FW_W) ?
                         $clog2(MAX_FRAME_WIDTH + 1) : FW_W;
  localparam logic [WID_W-1:0] MAX_W    = WID_W'(MAX_FRAME_WIDTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FRAME_PIXELS - 1);

  logic [COL_W-1:0]      column;
  logic [IDX_W-1:0]      pixel_index;
  logic [SPAN_LEN_W-1:0] run_length;
  logic [IDX_W-1:0]      run_start;
  logic [COUNT_W-1:0]    spans_in_frame;

  logic [COL_W-1:0]      column_next;
  logic [IDX_W-1:0]      pixel_index_next;
  logic [SPAN_LEN_W-1:0] run_length_next;
  logic [IDX_W-1:0]      run_start_next;
  logic [COUNT_W-1:0]    spans_in_frame_next;

  logic [WID_W-1:0]      fw_ext;
  logic [WID_W-1:0]      width;
  logic [WID_W-1:0]      col_plus;
  logic                  row_end;
  logic                  opaque;
  logic                  last;
  logic [SPAN_LEN_W-1:0] run_inc;
  logic                  span;
  logic [IDX_W-1:0]      start;
  logic [SPAN_LEN_W-1:0] len;

  always_comb begin
    fw_ext = WID_W'(cfg.frame_width);
    // A zero width acts as one; an oversized width is clipped to the maximum.
    if (cfg.frame_width == '0) begin
      width = WID_W'(1);
    end else if (fw_ext > MAX_W) begin
      width = MAX_W;
    end else begin
      width = fw_ext;
    end
    col_plus = WID_W'(column) + WID_W'(1);
    row_end  = col_plus >= width;
    opaque   = in_word.pixel != cfg.background_color;
    last     = in_word.last_in_frame;
    run_inc  = (run_length != '1) ? run_length + SPAN_LEN_W'(1) : run_length;

    span  = 1'b0;
    start = '0;
    len   = '0;
    run_length_next = '0;
    run_start_next  = run_start;
    if (opaque) begin
      if (run_length == '0) begin
        run_start_next = pixel_index;
      end
      if (row_end || last) begin
        span  = 1'b1;
        len   = run_inc;
        start = (run_length == '0) ? pixel_index : run_start;
      end else begin
        run_length_next = run_inc;
      end
    end else if (run_length != '0) begin
      // A background pixel closes the run that ended on the pixel before it.
      span  = 1'b1;
      len   = run_length;
      start = run_start;
    end

    spans_in_frame_next = (span && spans_in_frame != '1) ?
                          spans_in_frame + COUNT_W'(1) : spans_in_frame;

    column_next      = row_end ? '0 : column + COL_W'(1);
    pixel_index_next = (pixel_index == LAST_IDX) ? '0 : pixel_index + IDX_W'(1);

    has_result         = span || last;
    result.span_valid  = span;
    result.span_start  = SPAN_START_W'(start);
    result.span_length = len;
    result.frame_done  = last;
    result.zone_count  = spans_in_frame_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column         <= '0;
      pixel_index    <= '0;
      run_length     <= '0;
      spans_in_frame <= '0;
    end else if (accept) begin
      if (last) begin
        column         <= '0;
        pixel_index    <= '0;
        run_length     <= '0;
        spans_in_frame <= '0;
      end else begin
        column         <= column_next;
        pixel_index    <= pixel_index_next;
        run_length     <= run_length_next;
        spans_in_frame <= spans_in_frame_next;
      end
    end
  end

  // Start index of the open run; only read while run_length is nonzero.
  always_ff @(posedge clk) begin
    if (accept) begin
      run_start <= run_start_next;
    end
  end

endmodule

### rtl/core/osx_skid_out.sv
// Output register with one skid entry for the opaque span extractor.
// Holds result words while the downstream side stalls. Depends on osx_pkg.
module osx_skid_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  osx_pkg::osx_out_t push_word,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output osx_pkg::osx_out_t out_data
);
  import osx_pkg::*;

  logic     skid_valid;
  osx_out_t skid_word;
  logic     take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      out_data <= skid_valid ? skid_word : push_word;
    end
    if (push && out_valid && !take) begin
      skid_word <= push_word;
    end
  end

endmodule

### rtl/core/opaque_span_extractor_unit.sv
// Top level of the opaque span extractor: configuration registers, run
// tracker and output skid register. Depends on osx_pkg, osx_cfg_regs,
// osx_span_tracker and osx_skid_out.
//
//   channel   direction  handshake             word
//   in        input      in_valid / in_stall   osx_in_t: pixel, last_in_frame
//   out       output     out_valid / out_stall osx_out_t: span and count fields
//   cfg       input      cfg_write             cfg_index, cfg_data
//
// One pixel word is accepted per clock while in_stall is low; its result
// word, if any, is registered in the out register or, on a stall, the skid entry.
// The rate is set by the run tracker, a single compare-and-count step that
// updates its state in the cycle the pixel is accepted.
// Reset (synchronous, active high) empties the output path, zeroes the
// column, pixel index, run length and span count, and loads frame width 32
// and background color 0.
// A stalled output is backed by one skid entry; in_stall rises only while
// that entry is occupied, so input keeps flowing until a stall fills it.
module opaque_span_extractor_unit #(
  parameter int MAX_FRAME_WIDTH  = osx_pkg::DEF_MAX_FRAME_WIDTH,
  parameter int MAX_FRAME_PIXELS = osx_pkg::DEF_MAX_FRAME_PIXELS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  osx_pkg::osx_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output osx_pkg::osx_out_t              out_data,
  input  logic                           cfg_write,
  input  logic [osx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [osx_pkg::CFG_DATA_W-1:0] cfg_data
);
  import osx_pkg::*;

  osx_cfg_t cfg;
  osx_out_t result;
  logic     has_result;
  logic     accept;
  logic     skid_full;

  // A word is taken whenever the skid entry is free.
  assign in_stall = skid_full;
  assign accept   = in_valid && !skid_full;

  osx_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  osx_span_tracker #(
    .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
    .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .in_word    (in_data),
    .has_result (has_result),
    .result     (result)
  );

  // Only pixels that close a span or end a frame produce a result word.
  osx_skid_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && has_result),
    .push_word (result),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/core/osx_checker.sv
// Port-level checks for the opaque span extractor, bound to the top level.
// Depends on osx_pkg and opaque_span_extractor_unit.
module osx_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input osx_pkg::osx_in_t               in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input osx_pkg::osx_out_t              out_data
);
  import osx_pkg::*;

  // A stalled pixel word stays put until the block takes it.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("stalled pixel word changed");

  // Every word carries a span, a frame end, or both.
  a_word_has_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.span_valid || out_data.frame_done))
    else $error("result word with neither span nor frame end");

  // A span is never empty.
  a_span_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.span_valid) |-> (out_data.span_length != '0))
    else $error("zero-length span");

  // The count includes the span carried in the same word.
  a_count_covers_span: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.span_valid) |-> (out_data.zone_count != '0))
    else $error("span reported with zero span count");

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result word changed");

endmodule

bind opaque_span_extractor_unit osx_checker u_osx_checker (.*);
